>>> rtl/core/pidr_pkg.sv
// Shared types and constants of the distance PI regulator core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package pidr_pkg;

	// fixed-point formats
	localparam int GAIN_FRAC = 8;
	localparam int DIST_FRAC = 4;
	localparam int STEP_FRAC = 16;

	// shared bit-serial multiplier
	localparam int MUL_OP_W = 16;
	localparam int MUL_W = 49;
	localparam int CAP_W = 48;
	localparam logic [MUL_W-1:0] MUL_SAT = MUL_W'(1) << (MUL_W - 1);
	localparam logic [CAP_W-1:0] MAG_CAP = CAP_W'(1) << (CAP_W - 1);

	localparam int FILTER_ONE = 256;
	localparam int SETPOINT_STEP = 16;
	localparam int SETPOINT_MAX = 1600;
	localparam int SETPOINT_RESET = 2880;
	localparam int CTRL_LIMIT = 100;
	localparam logic signed [7:0] SPEED_RESET = 8'sd35;
	localparam logic signed [7:0] SPEED_MAX = 8'sh7F;
	localparam logic signed [7:0] SPEED_MIN = 8'sh80;

	localparam logic [15:0] PROP_GAIN_RESET = 16'd128;
	localparam logic [15:0] INTEGRAL_STEP_RESET = 16'd1311;
	localparam logic [8:0] FILTER_WEIGHT_RESET = 9'd64;
	localparam logic [15:0] DEAD_ZONE_RESET = 16'd8;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN     = 3'd0,
		CFG_INTEGRAL_STEP = 3'd1,
		CFG_FILTER_WEIGHT = 3'd2,
		CFG_DEAD_ZONE     = 3'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		KIND_TICK      = 3'd0,
		KIND_TOGGLE    = 3'd1,
		KIND_SP_UP     = 3'd2,
		KIND_SP_DOWN   = 3'd3,
		KIND_SPEED_UP  = 3'd4,
		KIND_SPEED_DN  = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FLT_LO,
		ST_FLT_LO_W,
		ST_FLT_HI,
		ST_FLT_HI_W,
		ST_FILT_END,
		ST_ERR,
		ST_P_MUL,
		ST_P_MUL_W,
		ST_T_MUL,
		ST_T_MUL_W,
		ST_I_MUL,
		ST_I_MUL_W,
		ST_SUM,
		ST_MANUAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integral_step;
		logic [8:0]  filter_weight;
		logic [15:0] dead_zone;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic                accumulate;
		logic [MUL_OP_W-1:0] multiplier;
		logic [MUL_W-1:0]    multiplicand;
	} mul_req_t;

	typedef struct packed {
		logic             busy;
		logic [CAP_W-1:0] product;
	} mul_rsp_t;

endpackage

>>> rtl/core/pidr_serial_mult.sv
// Bit-serial saturating shift-add multiplier, one multiplier bit per cycle.
// Depends on pidr_pkg.
`timescale 1ns / 1ps

module pidr_serial_mult
	import pidr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [MUL_OP_W-1:0] mult_q;
	logic [MUL_W-1:0]    mcand_q;
	logic [MUL_W-1:0]    acc_q;
	logic                busy_q;

	logic [MUL_W:0]   sum;
	logic [MUL_W:0]   dbl;
	logic [MUL_W-1:0] acc_nx;
	logic [MUL_W-1:0] mcand_nx;

	// all terms are non-negative, so saturating each step equals capping the total
	always_comb begin
		sum = {1'b0, acc_q} + {1'b0, mcand_q};
		dbl = {mcand_q, 1'b0};
		if (!mult_q[0]) begin
			acc_nx = acc_q;
		end else if (sum > {1'b0, MUL_SAT}) begin
			acc_nx = MUL_SAT;
		end else begin
			acc_nx = sum[MUL_W-1:0];
		end
		mcand_nx = (dbl > {1'b0, MUL_SAT}) ? MUL_SAT : dbl[MUL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q  <= '0;
			mcand_q <= '0;
			acc_q   <= '0;
			busy_q  <= 1'b0;
		end else if (req.start) begin
			mult_q  <= req.multiplier;
			mcand_q <= req.multiplicand;
			acc_q   <= req.accumulate ? acc_q : '0;
			busy_q  <= |req.multiplier;
		end else if (busy_q) begin
			acc_q   <= acc_nx;
			mcand_q <= mcand_nx;
			mult_q  <= mult_q >> 1;
			busy_q  <= |mult_q[MUL_OP_W-1:1];
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.product = (acc_q > MUL_W'(MAG_CAP)) ? MAG_CAP : acc_q[CAP_W-1:0];

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> mult_q == '0)
		else $error("multiplier idle with bits left");

	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= MUL_SAT && mcand_q <= MUL_SAT)
		else $error("accumulator beyond saturation level");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q == $past(|req.multiplier))
		else $error("busy flag wrong after start");

endmodule

>>> rtl/core/pidr_regulator.sv
// Sequencer and datapath: filter, dead band, PI law, clamps and wheel mixing.
// Depends on pidr_pkg; drives one pidr_serial_mult through mul_req/mul_rsp.
`timescale 1ns / 1ps

module pidr_regulator
	import pidr_pkg::*;
#(
	parameter int DIST_WIDTH = 16,
	parameter int OUT_FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  in_kind,
	input  logic [DIST_WIDTH-1:0]       in_sample,
	output mul_req_t                    mul_req,
	input  mul_rsp_t                    mul_rsp,
	input  logic                        out_free,
	output logic                        push,
	output logic [8:0]                  wheel_left,
	output logic [8:0]                  wheel_right,
	output logic [DIST_WIDTH-1:0]       filtered_distance,
	output logic [DIST_WIDTH:0]         control_error,
	output logic [OUT_FRAC_BITS+7:0]    control_output,
	output logic                        auto_active
);

	localparam int DW = DIST_WIDTH;
	localparam int F = OUT_FRAC_BITS;
	localparam int OW = F + 8;
	localparam int SPW = (DW > 12) ? DW : 12;
	localparam int EW = ((DW > 16) ? DW : 16) + 2;
	localparam int RW = 52;
	localparam int SW = RW + 4;
	localparam int WW = F + 10;
	localparam int SP = GAIN_FRAC + DIST_FRAC - F;
	localparam int SPR = (SP > 0) ? SP : 0;
	localparam int SPL = (SP < 0) ? -SP : 0;
	localparam int SPR1 = (SP > 1) ? SP - 1 : 0;
	localparam int SI = GAIN_FRAC + DIST_FRAC + STEP_FRAC - F;
	localparam logic [RW-1:0] RND_P = (SP > 0) ? (RW'(1) << SPR1) : '0;
	localparam logic [RW-1:0] RND_I = RW'(1) << (SI - 1);
	localparam logic signed [SW-1:0] LIM = SW'(CTRL_LIMIT * (2 ** F));

	state_t state_q, state_d;

	// regulator state
	logic [DW-1:0]         filt_q;
	logic                  first_q;
	logic signed [EW-1:0]  prev_e_q;
	logic signed [OW-1:0]  integ_q;
	logic signed [OW-1:0]  held_q;
	logic [SPW-1:0]        sp_q;
	logic                  auto_q;
	logic signed [7:0]     speed_q;

	// per-tick work registers
	logic [DW-1:0]         ym_q;
	logic [DW-1:0]         yp_q;
	logic [8:0]            a_q;
	logic [DW-1:0]         y_q;
	logic signed [EW-1:0]  e_q;
	logic signed [SW-1:0]  p_q;
	logic [CAP_W-1:0]      t_q;
	logic signed [SW-1:0]  ui_q;
	logic signed [OW-1:0]  u_q;

	logic                  accept;
	logic [SPW:0]          sp_sum;
	logic [SPW-1:0]        sp_up;
	logic [SPW-1:0]        sp_down;
	logic [8:0]            a_inv;
	logic [CAP_W-1:0]      y_sum;
	logic [DW-1:0]         y_c;
	logic signed [EW-1:0]  ew, dzs, e_c;
	logic [EW-1:0]         emag, pmag;
	logic [RW-1:0]         p_ext, p_r, i_r;
	logic signed [SW-1:0]  p_c, inc_c, u_c, i_clamp;
	logic signed [7:0]     spd;
	logic signed [WW-1:0]  base, vl, vr;

	function automatic logic signed [SW-1:0] clamp_ctrl(input logic signed [SW-1:0] v);
		if (v > LIM) begin
			return LIM;
		end else if (v < -LIM) begin
			return -LIM;
		end
		return v;
	endfunction

	// truncate toward zero to whole units
	function automatic logic [8:0] trunc_wheel(input logic signed [WW-1:0] v);
		logic [WW-1:0] m;
		logic [WW-1:0] q;
		m = (v < 0) ? WW'(-v) : WW'(v);
		q = m >> F;
		return (v < 0) ? 9'(-q) : 9'(q);
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		sp_sum  = (SPW+1)'(sp_q) + (SPW+1)'(SETPOINT_STEP);
		sp_up   = (sp_sum > (SPW+1)'(SETPOINT_MAX)) ? SPW'(SETPOINT_MAX) : sp_sum[SPW-1:0];
		sp_down = (sp_q < SPW'(SETPOINT_STEP)) ? '0 : sp_q - SPW'(SETPOINT_STEP);

		a_inv = 9'(FILTER_ONE) - a_q;
		y_sum = mul_rsp.product + CAP_W'(FILTER_ONE / 2);
		y_c   = y_sum[DW+7:8];

		ew  = signed'(EW'(sp_q)) - signed'(EW'(y_q));
		dzs = signed'(EW'(cfg.dead_zone));
		if (ew > dzs) begin
			e_c = ew - dzs;
		end else if (ew < -dzs) begin
			e_c = ew + dzs;
		end else begin
			e_c = '0;
		end
		emag = e_q[EW-1] ? EW'(-e_q) : EW'(e_q);
		pmag = prev_e_q[EW-1] ? EW'(-prev_e_q) : EW'(prev_e_q);

		// rescale to the output format, magnitude rounded half away from zero
		p_ext = RW'(mul_rsp.product);
		p_r   = (SP > 0) ? ((p_ext + RND_P) >> SPR) : (p_ext << SPL);
		p_c   = e_q[EW-1] ? -signed'(SW'(p_r)) : signed'(SW'(p_r));
		i_r   = (p_ext + RND_I) >> SI;
		inc_c = prev_e_q[EW-1] ? -signed'(SW'(i_r)) : signed'(SW'(i_r));

		u_c     = clamp_ctrl(p_q + ui_q);
		i_clamp = clamp_ctrl(ui_q);

		spd  = auto_q ? speed_q : 8'sd0;
		base = signed'(WW'(spd)) <<< F;
		vl   = base - signed'(WW'(u_q));
		vr   = base + signed'(WW'(u_q));
	end

	always_comb begin
		state_d = state_q;
		mul_req = '0;
		push    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_kind == KIND_TICK) begin
					state_d = ST_FLT_LO;
				end
			end
			ST_FLT_LO: begin
				mul_req.start        = 1'b1;
				mul_req.multiplier   = MUL_OP_W'(a_q);
				mul_req.multiplicand = MUL_W'(ym_q);
				state_d = ST_FLT_LO_W;
			end
			ST_FLT_LO_W: begin
				if (!mul_rsp.busy) state_d = ST_FLT_HI;
			end
			ST_FLT_HI: begin
				mul_req.start        = 1'b1;
				mul_req.accumulate   = 1'b1;
				mul_req.multiplier   = MUL_OP_W'(a_inv);
				mul_req.multiplicand = MUL_W'(yp_q);
				state_d = ST_FLT_HI_W;
			end
			ST_FLT_HI_W: begin
				if (!mul_rsp.busy) state_d = ST_FILT_END;
			end
			ST_FILT_END: begin
				state_d = auto_q ? ST_ERR : ST_MANUAL;
			end
			ST_ERR: begin
				state_d = ST_P_MUL;
			end
			ST_P_MUL: begin
				mul_req.start        = 1'b1;
				mul_req.multiplier   = cfg.prop_gain;
				mul_req.multiplicand = MUL_W'(emag);
				state_d = ST_P_MUL_W;
			end
			ST_P_MUL_W: begin
				if (!mul_rsp.busy) state_d = ST_T_MUL;
			end
			ST_T_MUL: begin
				mul_req.start        = 1'b1;
				mul_req.multiplier   = cfg.prop_gain;
				mul_req.multiplicand = MUL_W'(pmag);
				state_d = ST_T_MUL_W;
			end
			ST_T_MUL_W: begin
				if (!mul_rsp.busy) state_d = ST_I_MUL;
			end
			ST_I_MUL: begin
				mul_req.start        = 1'b1;
				mul_req.multiplier   = cfg.integral_step;
				mul_req.multiplicand = MUL_W'(t_q);
				state_d = ST_I_MUL_W;
			end
			ST_I_MUL_W: begin
				if (!mul_rsp.busy) state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_DONE;
			end
			ST_MANUAL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			filt_q   <= '0;
			first_q  <= 1'b0;
			prev_e_q <= '0;
			integ_q  <= '0;
			held_q   <= '0;
			sp_q     <= SPW'(SETPOINT_RESET);
			auto_q   <= 1'b0;
			speed_q  <= SPEED_RESET;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (in_kind)
					KIND_TOGGLE:   auto_q <= ~auto_q;
					KIND_SP_UP:    sp_q <= sp_up;
					KIND_SP_DOWN:  sp_q <= sp_down;
					KIND_SPEED_UP: begin
						if (speed_q != SPEED_MAX) speed_q <= speed_q + 8'sd1;
					end
					KIND_SPEED_DN: begin
						if (speed_q != SPEED_MIN) speed_q <= speed_q - 8'sd1;
					end
					default: ;
				endcase
			end
			if (state_q == ST_SUM) begin
				integ_q  <= i_clamp[OW-1:0];
				held_q   <= u_c[OW-1:0];
				prev_e_q <= e_q;
				filt_q   <= y_q;
				first_q  <= 1'b1;
			end
			if (state_q == ST_MANUAL) begin
				// setpoint tracks, integrator preloaded for bumpless return
				integ_q  <= held_q;
				prev_e_q <= '0;
				sp_q     <= SPW'(y_q);
				filt_q   <= y_q;
				first_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_kind == KIND_TICK) begin
			ym_q <= in_sample;
			yp_q <= first_q ? filt_q : in_sample;
			a_q  <= (cfg.filter_weight > 9'(FILTER_ONE)) ? 9'(FILTER_ONE) : cfg.filter_weight;
		end
		case (state_q)
			ST_FILT_END: y_q <= y_c;
			ST_ERR:      e_q <= e_c;
			ST_P_MUL_W:  if (!mul_rsp.busy) p_q <= p_c;
			ST_T_MUL_W:  if (!mul_rsp.busy) t_q <= mul_rsp.product;
			ST_I_MUL_W:  if (!mul_rsp.busy) ui_q <= SW'(integ_q) + inc_c;
			ST_SUM:      u_q <= u_c[OW-1:0];
			ST_MANUAL: begin
				u_q <= held_q;
				e_q <= '0;
			end
			default: ;
		endcase
	end

	assign wheel_left        = trunc_wheel(vl);
	assign wheel_right       = trunc_wheel(vr);
	assign filtered_distance = y_q;
	assign control_error     = e_q[DW:0];
	assign control_output    = u_q;
	assign auto_active       = auto_q;

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy)
		else $error("multiplier started while busy");

	a_integ_limit: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(integ_q) <= LIM && SW'(integ_q) >= -LIM && SW'(held_q) <= LIM
		&& SW'(held_q) >= -LIM)
		else $error("integrator or held output beyond limit");

	a_push_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> first_q && out_free)
		else $error("result pushed before filter was seeded");

endmodule

>>> rtl/core/pi_distance_regulator_deadzone_core.sv
// Top level of the wall-distance PI regulator: stream ports, config registers,
// output register. Depends on pidr_pkg, pidr_serial_mult, pidr_regulator.
// Events are applied on accept and leave the sequencer idle. A tick runs the two filter products,
// then either the manual update or, in auto mode, the error, the P product, the product of prop_gain
// and the previous error, the integral step product and the sum, before it reaches the output register.
// One item at a time; arst_n resets the regulator state: manual, setpoint 180.0, speed 35, defaults.
`timescale 1ns / 1ps

module pi_distance_regulator_deadzone_core
	import pidr_pkg::*;
#(
	parameter int DIST_WIDTH = 16,
	parameter int OUT_FRAC_BITS = 8,
	localparam int IN_TDW = ((DIST_WIDTH + 7) / 8) * 8,
	localparam int OUT_BITS = 9 + 9 + DIST_WIDTH + (DIST_WIDTH + 1) + (OUT_FRAC_BITS + 8) + 1,
	localparam int OUT_TDW = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_TDW-1:0]    s_axis_tdata,   // distance_sample
	input  logic [2:0]           s_axis_tuser,   // kind

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// wheel_left, wheel_right, filtered_distance, control_error, control_output,
	// auto_active
	output logic [OUT_TDW-1:0]   m_axis_tdata,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cfg_t     cfg_q;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic                        out_valid_q;
	logic [OUT_TDW-1:0]          out_data_q;
	logic                        out_free;
	logic                        push;
	logic [8:0]                  wheel_left, wheel_right;
	logic [DIST_WIDTH-1:0]       filtered_distance;
	logic [DIST_WIDTH:0]         control_error;
	logic [OUT_FRAC_BITS+7:0]    control_output;
	logic                        auto_active;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= PROP_GAIN_RESET;
			cfg_q.integral_step <= INTEGRAL_STEP_RESET;
			cfg_q.filter_weight <= FILTER_WEIGHT_RESET;
			cfg_q.dead_zone     <= DEAD_ZONE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_data;
				CFG_INTEGRAL_STEP: cfg_q.integral_step <= cfg_data;
				CFG_FILTER_WEIGHT: cfg_q.filter_weight <= cfg_data[8:0];
				CFG_DEAD_ZONE:     cfg_q.dead_zone     <= cfg_data;
				default: ;
			endcase
		end
	end

	pidr_serial_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	pidr_regulator #(
		.DIST_WIDTH    (DIST_WIDTH),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_reg (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.in_kind           (s_axis_tuser),
		.in_sample         (s_axis_tdata[DIST_WIDTH-1:0]),
		.mul_req           (mul_req),
		.mul_rsp           (mul_rsp),
		.out_free          (out_free),
		.push              (push),
		.wheel_left        (wheel_left),
		.wheel_right       (wheel_right),
		.filtered_distance (filtered_distance),
		.control_error     (control_error),
		.control_output    (control_output),
		.auto_active       (auto_active)
	);

	// output register frees the sequencer while a result waits downstream
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q <= OUT_TDW'({auto_active, control_output, control_error,
				filtered_distance, wheel_right, wheel_left});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the wall-distance PI regulator core.
// Drives tick and event requests, predicts the wheel commands and checks them.
// Depends on pidr_pkg and pi_distance_regulator_deadzone_core.
`timescale 1ns / 1ps

module testbench;
	import pidr_pkg::*;

	localparam int OUT_FRAC = 8;
	localparam longint CTRL_ONE = 64'sd1 <<< OUT_FRAC;
	localparam longint MAG_LIMIT = 64'sd1 <<< 47;
	localparam longint RES_LIMIT = 64'sd1 <<< 60;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS = 135;
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	// same layout as m_axis_tdata, lowest field last
	typedef struct packed {
		logic              auto_on;
		logic signed [15:0] ctrl_out;
		logic signed [16:0] ctrl_err;
		logic [15:0]        filt;
		logic signed [8:0]  wheel_r;
		logic signed [8:0]  wheel_l;
	} wheel_cmd_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PROP_GAIN;
	logic [15:0] cfg_data = '0;

	// regulator state as the block should hold it
	longint kp_q = longint'(PROP_GAIN_RESET);
	longint step_q = longint'(INTEGRAL_STEP_RESET);
	longint fw_q = longint'(FILTER_WEIGHT_RESET);
	longint dz_q = longint'(DEAD_ZONE_RESET);
	longint flt_q = 0;
	bit seen_q = 1'b0;
	longint prev_err_q = 0;
	longint integ_q = 0;
	longint held_q = 0;
	longint sp_q = longint'(SETPOINT_RESET);
	bit auto_q = 1'b0;
	int speed_q = int'(SPEED_RESET);

	wheel_cmd_t pending_cmds[$];
	int bad_results = 0;
	int burst_left = 0;
	int hold_req = 0;

	pi_distance_regulator_deadzone_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic longint to_ctrl_scale(longint mag, bit neg, int frac_in);
		int s;
		longint r;
		s = frac_in - OUT_FRAC;
		if (mag > MAG_LIMIT) mag = MAG_LIMIT;
		r = (mag + (64'sd1 <<< (s - 1))) >>> s;
		if (r > RES_LIMIT) r = RES_LIMIT;
		return neg ? -r : r;
	endfunction

	function automatic longint clamp_ctrl(longint v);
		longint lim;
		lim = CTRL_LIMIT * CTRL_ONE;
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint toward_zero(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		m = m >>> OUT_FRAC;
		return (v < 0) ? -m : m;
	endfunction

	task automatic advance_regulator(input logic [2:0] kind, input logic [15:0] sample);
		longint ym, a, y, ew, e, emag, pmag, t, p, inc, ui, u, spd;
		wheel_cmd_t cmd;
		ym = longint'(sample);
		case (kind)
			KIND_TOGGLE: auto_q = !auto_q;
			KIND_SP_UP: begin
				sp_q += SETPOINT_STEP;
				if (sp_q > SETPOINT_MAX) sp_q = SETPOINT_MAX;
			end
			KIND_SP_DOWN: sp_q = (sp_q < SETPOINT_STEP) ? 0 : sp_q - SETPOINT_STEP;
			KIND_SPEED_UP: if (speed_q < SPEED_MAX) speed_q++;
			KIND_SPEED_DN: if (speed_q > SPEED_MIN) speed_q--;
			KIND_TICK: begin
				if (!seen_q) begin
					flt_q = ym;
					seen_q = 1'b1;
				end
				a = (fw_q > FILTER_ONE) ? longint'(FILTER_ONE) : fw_q;
				y = ((FILTER_ONE - a) * flt_q + a * ym + FILTER_ONE / 2) >>> 8;
				if (auto_q) begin
					ew = sp_q - y;
					if (ew > dz_q) e = ew - dz_q;
					else if (ew < -dz_q) e = ew + dz_q;
					else e = 0;
					emag = (e < 0) ? -e : e;
					p = to_ctrl_scale(kp_q * emag, e < 0, GAIN_FRAC + DIST_FRAC);
					pmag = (prev_err_q < 0) ? -prev_err_q : prev_err_q;
					t = kp_q * pmag;
					if (t > MAG_LIMIT) t = MAG_LIMIT;
					if (step_q == 0 || t == 0) inc = 0;
					else inc = to_ctrl_scale(t * step_q, prev_err_q < 0,
						GAIN_FRAC + DIST_FRAC + STEP_FRAC);
					ui = integ_q + inc;
					u = clamp_ctrl(p + ui);
					integ_q = clamp_ctrl(ui);
					held_q = u;
					spd = speed_q;
				end else begin
					// manual: hold output, track setpoint, preload integrator
					spd = 0;
					u = held_q;
					sp_q = y;
					e = 0;
					integ_q = u;
				end
				prev_err_q = e;
				flt_q = y;
				cmd.wheel_l = 9'(toward_zero(spd * CTRL_ONE - u));
				cmd.wheel_r = 9'(toward_zero(spd * CTRL_ONE + u));
				cmd.filt = y[15:0];
				cmd.ctrl_err = e[16:0];
				cmd.ctrl_out = u[15:0];
				cmd.auto_on = auto_q;
				pending_cmds.push_back(cmd);
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [2:0] kind, input logic [15:0] sample);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				4, 5, 6, 7: gap = $urandom_range(1, 4);
				8: gap = $urandom_range(5, 20);
				default: gap = $urandom_range(21, 60);
			endcase
		end
		burst_left--;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sample;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		advance_regulator(kind, sample);
	endtask

	// events give no result, so allow the block to finish after the last one
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_PROP_GAIN: kp_q = longint'(data);
			CFG_INTEGRAL_STEP: step_q = longint'(data);
			CFG_FILTER_WEIGHT: fw_q = longint'(data[8:0]);
			CFG_DEAD_ZONE: dz_q = longint'(data);
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [15:0] kp, input logic [15:0] step,
			input logic [15:0] fw, input logic [15:0] dz);
		wait_idle();
		write_reg(CFG_PROP_GAIN, kp);
		write_reg(CFG_INTEGRAL_STEP, step);
		write_reg(CFG_FILTER_WEIGHT, fw);
		write_reg(CFG_DEAD_ZONE, dz);
		cfg_valid <= 1'b0;
	endtask

	task automatic ensure_mode(input bit want_auto);
		if (auto_q != want_auto) send_item(KIND_TOGGLE, 16'($urandom));
	endtask

	function automatic logic [2:0] pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < (auto_q ? 2 : 15)) return KIND_TOGGLE;
		roll = $urandom_range(0, 99);
		if (roll < 72) return KIND_TICK;
		if (roll < 80) return KIND_SP_UP;
		if (roll < 88) return KIND_SP_DOWN;
		if (roll < 93) return KIND_SPEED_UP;
		if (roll < 98) return KIND_SPEED_DN;
		return (roll == 98) ? KIND_SPARE_LO : KIND_SPARE_HI;
	endfunction

	// mostly near the setpoint so the PI law works unsaturated
	function automatic logic [15:0] pick_sample();
		int span, v;
		if ($urandom_range(0, 99) < 15) return 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: span = 8;
			1: span = 64;
			2: span = 512;
			default: span = 4096;
		endcase
		v = int'(sp_q) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return 16'(v);
	endfunction

	// receiver: random stall patterns plus an optional long hold-off
	initial begin
		rx_mode_t mode;
		int span, hold_left, rx_phase;
		hold_left = 0;
		rx_phase = 0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(50, 400);
			repeat (span) begin
				@(posedge clk);
				rx_phase++;
				if (hold_req > 0) begin
					hold_left = hold_req;
					hold_req = 0;
				end
				if (hold_left > 0) begin
					hold_left--;
					m_axis_tready <= 1'b0;
				end else begin
					case (mode)
						RX_OPEN: m_axis_tready <= 1'b1;
						RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
						RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
						default: m_axis_tready <= (rx_phase % 4 == 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		wheel_cmd_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[67:0];
			if (pending_cmds.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result wl=%0d wr=%0d fd=%0d err=%0d out=%0d auto=%0d",
						got.wheel_l, got.wheel_r, got.filt, got.ctrl_err, got.ctrl_out,
						got.auto_on);
			end else begin
				want = pending_cmds.pop_front();
				if (got !== want) begin
					bad_results++;
					if (bad_results <= 10) begin
						$display("mismatch exp wl=%0d wr=%0d fd=%0d err=%0d out=%0d auto=%0d",
							want.wheel_l, want.wheel_r, want.filt, want.ctrl_err,
							want.ctrl_out, want.auto_on);
						$display("         got wl=%0d wr=%0d fd=%0d err=%0d out=%0d auto=%0d",
							got.wheel_l, got.wheel_r, got.filt, got.ctrl_err,
							got.ctrl_out, got.auto_on);
					end
				end
			end
		end
	end

	// reset registers, filter seeded by the very first sample
	task automatic test_first_sample();
		send_item(KIND_TICK, 16'hA5C3);
		send_item(KIND_TICK, 16'h0000);
		send_item(KIND_TICK, 16'hFFFF);
		send_item(KIND_TICK, 16'h0001);
	endtask

	// setpoint above 100.0 clamps on the first up step; spare kinds are ignored
	task automatic test_mode_and_steps();
		send_item(KIND_TOGGLE, 16'hFFFF);
		send_item(KIND_TICK, 16'h0B40);
		send_item(KIND_SP_UP, 16'h0000);
		send_item(KIND_TICK, 16'h0B40);
		send_item(KIND_SP_DOWN, 16'h5555);
		send_item(KIND_TICK, 16'h0640);
		send_item(KIND_SPEED_UP, 16'hAAAA);
		send_item(KIND_SPEED_DN, 16'h1234);
		send_item(KIND_SPARE_LO, 16'hFFFF);
		send_item(KIND_SPARE_HI, 16'h0000);
		send_item(KIND_TICK, 16'h0600);
		send_item(KIND_TOGGLE, 16'h0000);
		send_item(KIND_TICK, 16'h0700);
		send_item(KIND_TOGGLE, 16'h0000);
		send_item(KIND_TICK, 16'h0700);
	endtask

	// setpoint down stops at zero
	task automatic test_setpoint_floor();
		apply_config(PROP_GAIN_RESET, INTEGRAL_STEP_RESET, 16'd256, DEAD_ZONE_RESET);
		ensure_mode(1'b0);
		send_item(KIND_TICK, 16'd10);
		send_item(KIND_SP_DOWN, 16'd0);
		send_item(KIND_SP_DOWN, 16'd0);
		ensure_mode(1'b1);
		send_item(KIND_TICK, 16'd10);
		send_item(KIND_TICK, 16'd0);
	endtask

	task automatic run_extreme_setting(input logic [15:0] kp, input logic [15:0] step,
			input logic [15:0] fw, input logic [15:0] dz);
		apply_config(kp, step, fw, dz);
		ensure_mode(1'b0);
		send_item(KIND_TICK, 16'h4000);
		ensure_mode(1'b1);
		send_item(KIND_TICK, 16'h0000);
		send_item(KIND_TICK, 16'hFFFF);
		send_item(KIND_TICK, 16'h0000);
		send_item(KIND_SP_UP, 16'h0000);
		send_item(KIND_TICK, 16'hFFFF);
		send_item(KIND_TICK, 16'h4000);
	endtask

	// weights above one act as one; unused index and upper data bits are dropped
	task automatic test_config_extremes();
		run_extreme_setting(16'd0, 16'd0, 16'd0, 16'd0);
		run_extreme_setting(16'hFFFF, 16'hFFFF, 16'd256, 16'd0);
		run_extreme_setting(16'hFFFF, 16'hFFFF, 16'd256, 16'hFFFF);
		run_extreme_setting(16'd1, 16'd1, 16'd1, 16'd1);
		run_extreme_setting(16'hFFFF, 16'hFFFF, 16'd300, 16'd0);
		run_extreme_setting(16'd256, 16'hFFFF, 16'hFF40, 16'd4);
		wait_idle();
		write_reg(CFG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_item(KIND_TICK, 16'h2000);
		send_item(KIND_TICK, 16'h6000);
	endtask

	// drive speed into both saturation limits with saturated control output
	task automatic test_speed_limits();
		int i;
		apply_config(16'hFFFF, INTEGRAL_STEP_RESET, 16'd256, 16'd0);
		ensure_mode(1'b0);
		send_item(KIND_TICK, 16'd800);
		ensure_mode(1'b1);
		for (i = 0; i < 100; i++) begin
			send_item(KIND_SPEED_UP, 16'($urandom));
			if (i % 10 == 9) send_item(KIND_TICK, (i % 20 == 9) ? 16'h0000 : 16'hFFFF);
		end
		for (i = 0; i < 260; i++) begin
			send_item(KIND_SPEED_DN, 16'($urandom));
			if (i % 10 == 9) send_item(KIND_TICK, (i % 20 == 9) ? 16'h0000 : 16'hFFFF);
		end
		for (i = 0; i < 130; i++) send_item(KIND_SPEED_UP, 16'($urandom));
	endtask

	// long receiver hold-off fills the block, then a full drain before more ticks
	task automatic test_backpressure();
		apply_config(PROP_GAIN_RESET, INTEGRAL_STEP_RESET, FILTER_WEIGHT_RESET, DEAD_ZONE_RESET);
		ensure_mode(1'b1);
		wait_idle();
		hold_req = HOLD_CYCLES;
		repeat (12) send_item(KIND_TICK, pick_sample());
		wait_idle();
		repeat (8) send_item(KIND_TICK, pick_sample());
	endtask

	task automatic test_random_phases();
		int ph;
		logic [15:0] kp, step, fw, dz;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0: kp = 0;
				1: kp = 16'hFFFF;
				2, 3, 4, 5, 6: kp = 16'($urandom_range(32, 1024));
				default: kp = 16'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: step = 0;
				1: step = 16'hFFFF;
				2, 3, 4, 5, 6: step = 16'($urandom_range(100, 5000));
				default: step = 16'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: fw = 0;
				1, 2: fw = 256;
				default: fw = 16'($urandom_range(1, 255));
			endcase
			case ($urandom_range(0, 19))
				0, 1, 2, 3: dz = 0;
				4: dz = 16'hFFFF;
				5, 6, 7, 8: dz = 16'($urandom);
				default: dz = 16'($urandom_range(0, 64));
			endcase
			apply_config(kp, step, fw, dz);
			repeat (PHASE_ITEMS) send_item(pick_kind(), pick_sample());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_first_sample();
		test_mode_and_steps();
		test_setpoint_floor();
		test_config_extremes();
		test_speed_limits();
		test_backpressure();
		test_random_phases();
		wait_idle();
		if (bad_results == 0 && pending_cmds.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
